>>> rtl/dsv_pkg.sv
// Package for the date string validator.
// Holds widths, character and position constants, status codes and the month length table.
// No dependencies.
package dsv_pkg;

	// Field widths.
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned ACC_W    = 7;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TODAY_YEAR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TODAY_MONTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TODAY_DAY   = 2'd2;

	// Reset values of the current date.
	localparam logic [YEAR_W-1:0]  TODAY_YEAR_RST  = 14'd2000;
	localparam logic [MONTH_W-1:0] TODAY_MONTH_RST = 4'd1;
	localparam logic [DAY_W-1:0]   TODAY_DAY_RST   = 5'd1;

	// Characters.
	localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

	// Character positions in a DD-MM-YYYY string.
	localparam logic [POS_W-1:0] POS_HYPHEN_A = 4'd2;
	localparam logic [POS_W-1:0] POS_HYPHEN_B = 4'd5;
	localparam logic [POS_W-1:0] POS_YEAR_LO  = 4'd8;
	localparam logic [POS_W-1:0] POS_LENGTH   = 4'd10;
	localparam logic [POS_W-1:0] POS_SAT      = 4'd11;

	// Result codes.
	typedef enum logic [1:0] {
		STATUS_VALID  = 2'd0,
		STATUS_FORMAT = 2'd1,
		STATUS_RANGE  = 2'd2,
		STATUS_FUTURE = 2'd3
	} status_t;

	// Number of days in a month; zero for a month outside 1 to 12.
	function automatic logic [DAY_W-1:0] month_days(input logic [ACC_W-1:0] month,
			input logic leap);
		logic [DAY_W-1:0] days;
		case (month)
			7'd2: begin
				days = leap ? 5'd29 : 5'd28;
			end
			7'd4, 7'd6, 7'd9, 7'd11: begin
				days = 5'd30;
			end
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: begin
				days = 5'd31;
			end
			default: begin
				days = 5'd0;
			end
		endcase
		return days;
	endfunction

endpackage

>>> rtl/date_string_validator_unit.sv
// Top level of the date string validator.
// Depends on dsv_pkg for widths, constants, status codes and the month length table.
//
// Usage: a DD-MM-YYYY date enters one character per item on the input channel
// (char_code, is_final), with is_final high on the last character. Only a final
// character produces a result: one status item on the output channel
// (0 valid, 1 bad format or length, 2 day or month out of range, 3 future date).
// The current date comes from the today registers on the write port
// (cfg_we, cfg_index, cfg_data); write them only while the block is idle.
// The block is three register stages: an input register, a snapshot register
// that holds the parsed fields of a finished string, and the result register.
// One item is accepted every cycle unless in_stall is high; the status of a
// final character moves through the snapshot register into the result register.
// The accumulate step between input and snapshot register sets the cycle time.
// When the receiver stalls, the result register holds, the snapshot register
// fills behind it, and in_stall rises only when a final character in the input
// register cannot move on. Non-final characters keep flowing into the
// accumulators. Reset empties all stages, clears the string state and sets the
// current date to 1 January 2000.
module date_string_validator_unit
	import dsv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Character input channel.
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic                 is_final,
	// Status output channel.
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [YEAR_W-1:0]    cfg_data
);

	// Current date registers.
	logic [YEAR_W-1:0]  today_year_q;
	logic [MONTH_W-1:0] today_month_q;
	logic [DAY_W-1:0]   today_day_q;

	// Input register.
	logic              v_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              fin_s1;

	// String state.
	logic [POS_W-1:0]  pos_q;
	logic              fmt_bad_q;
	logic [ACC_W-1:0]  day_q;
	logic [ACC_W-1:0]  month_q;
	logic [YEAR_W-1:0] year_q;
	logic [ACC_W-1:0]  year_hi_q;
	logic [ACC_W-1:0]  year_lo_q;

	// Snapshot register of a finished string.
	logic              v_s2;
	logic [POS_W-1:0]  pos_s2;
	logic              fmt_bad_s2;
	logic [ACC_W-1:0]  day_s2;
	logic [ACC_W-1:0]  month_s2;
	logic [YEAR_W-1:0] year_s2;
	logic [ACC_W-1:0]  year_hi_s2;
	logic [ACC_W-1:0]  year_lo_s2;

	// Result register.
	logic    out_valid_q;
	status_t status_q;

	// Stage flow control.
	logic out_free;
	logic move_s2;
	logic s2_free;
	logic move_s1;
	logic in_accept;

	assign out_free  = !out_valid_q || !out_stall;
	assign move_s2   = v_s2 && out_free;
	assign s2_free   = !v_s2 || out_free;
	assign move_s1   = v_s1 && (!fin_s1 || s2_free);
	assign in_stall  = v_s1 && !move_s1;
	assign in_accept = in_valid && !in_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			today_year_q  <= TODAY_YEAR_RST;
			today_month_q <= TODAY_MONTH_RST;
			today_day_q   <= TODAY_DAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TODAY_YEAR: begin
					today_year_q <= cfg_data;
				end
				REG_TODAY_MONTH: begin
					today_month_q <= cfg_data[MONTH_W-1:0];
				end
				REG_TODAY_DAY: begin
					today_day_q <= cfg_data[DAY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (move_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1 <= char_code;
			fin_s1  <= is_final;
		end
	end

	// Character check and digit accumulation for the character in the input register.
	logic              is_digit;
	logic [3:0]        digit;
	logic [POS_W-1:0]  pos_nx;
	logic              fmt_bad_nx;
	logic [ACC_W-1:0]  day_nx;
	logic [ACC_W-1:0]  month_nx;
	logic [YEAR_W-1:0] year_nx;
	logic [ACC_W-1:0]  year_hi_nx;
	logic [ACC_W-1:0]  year_lo_nx;

	always_comb begin
		is_digit   = char_s1 inside {[CHAR_ZERO:CHAR_NINE]};
		digit      = char_s1[3:0];
		pos_nx     = (pos_q < POS_SAT) ? pos_q + 4'd1 : pos_q;
		fmt_bad_nx = fmt_bad_q;
		day_nx     = day_q;
		month_nx   = month_q;
		year_nx    = year_q;
		year_hi_nx = year_hi_q;
		year_lo_nx = year_lo_q;
		if (pos_q >= POS_LENGTH) begin
			fmt_bad_nx = 1'b1;
		end else if (pos_q == POS_HYPHEN_A || pos_q == POS_HYPHEN_B) begin
			if (char_s1 != CHAR_HYPHEN) begin
				fmt_bad_nx = 1'b1;
			end
		end else if (!is_digit) begin
			fmt_bad_nx = 1'b1;
		end else if (pos_q < POS_HYPHEN_A) begin
			day_nx = {day_q[ACC_W-4:0], 3'b000} + {day_q[ACC_W-2:0], 1'b0}
				+ ACC_W'(digit);
		end else if (pos_q < POS_HYPHEN_B) begin
			month_nx = {month_q[ACC_W-4:0], 3'b000} + {month_q[ACC_W-2:0], 1'b0}
				+ ACC_W'(digit);
		end else begin
			year_nx = {year_q[YEAR_W-4:0], 3'b000} + {year_q[YEAR_W-2:0], 1'b0}
				+ YEAR_W'(digit);
			// Century digits and the last two digits are kept apart for the leap rule.
			if (pos_q < POS_YEAR_LO) begin
				year_hi_nx = {year_hi_q[ACC_W-4:0], 3'b000}
					+ {year_hi_q[ACC_W-2:0], 1'b0} + ACC_W'(digit);
			end else begin
				year_lo_nx = {year_lo_q[ACC_W-4:0], 3'b000}
					+ {year_lo_q[ACC_W-2:0], 1'b0} + ACC_W'(digit);
			end
		end
	end

	// String state: updated by each non-final character, cleared by a final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			fmt_bad_q <= 1'b0;
			day_q     <= '0;
			month_q   <= '0;
			year_q    <= '0;
			year_hi_q <= '0;
			year_lo_q <= '0;
		end else if (move_s1) begin
			if (fin_s1) begin
				pos_q     <= '0;
				fmt_bad_q <= 1'b0;
				day_q     <= '0;
				month_q   <= '0;
				year_q    <= '0;
				year_hi_q <= '0;
				year_lo_q <= '0;
			end else begin
				pos_q     <= pos_nx;
				fmt_bad_q <= fmt_bad_nx;
				day_q     <= day_nx;
				month_q   <= month_nx;
				year_q    <= year_nx;
				year_hi_q <= year_hi_nx;
				year_lo_q <= year_lo_nx;
			end
		end
	end

	// Snapshot register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (move_s1 && fin_s1) begin
			v_s2 <= 1'b1;
		end else if (move_s2) begin
			v_s2 <= 1'b0;
		end
	end

	// Snapshot register payload.
	always_ff @(posedge clk) begin
		if (move_s1 && fin_s1) begin
			pos_s2     <= pos_nx;
			fmt_bad_s2 <= fmt_bad_nx;
			day_s2     <= day_nx;
			month_s2   <= month_nx;
			year_s2    <= year_nx;
			year_hi_s2 <= year_hi_nx;
			year_lo_s2 <= year_lo_nx;
		end
	end

	// Judgement of a finished string. The fields only matter once the format
	// is good, and then the year has exactly four digits.
	logic             leap;
	logic [DAY_W-1:0] days_in_month;
	status_t          status_nx;

	always_comb begin
		// A year ending in 00 is a leap year when its century is a multiple of four.
		leap = (year_lo_s2 == '0) ? (year_hi_s2[1:0] == 2'b00) : (year_lo_s2[1:0] == 2'b00);
		days_in_month = month_days(month_s2, leap);
		if (fmt_bad_s2 || pos_s2 != POS_LENGTH) begin
			status_nx = STATUS_FORMAT;
		end else if (month_s2 < 7'd1 || month_s2 > 7'd12) begin
			status_nx = STATUS_RANGE;
		end else if (day_s2 < 7'd1 || day_s2 > ACC_W'(days_in_month)) begin
			status_nx = STATUS_RANGE;
		end else if (year_s2 > today_year_q) begin
			status_nx = STATUS_FUTURE;
		end else if (year_s2 == today_year_q && month_s2 > ACC_W'(today_month_q)) begin
			status_nx = STATUS_FUTURE;
		end else if (year_s2 == today_year_q && month_s2 == ACC_W'(today_month_q)
				&& day_s2 > ACC_W'(today_day_q)) begin
			status_nx = STATUS_FUTURE;
		end else begin
			status_nx = STATUS_VALID;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= STATUS_VALID;
		end else if (move_s2) begin
			out_valid_q <= 1'b1;
			status_q    <= status_nx;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	// The character count never passes its saturation point.
	assert property (@(posedge clk) disable iff (!arst_n) pos_q <= POS_SAT)
		else $error("character position beyond saturation");

	// A final character that moves on leaves a cleared string state behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 && fin_s1 |=> pos_q == '0 && !fmt_bad_q && v_s2)
		else $error("string state not cleared after final character");

	// A final character blocked by a full snapshot stage stalls the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && fin_s1 && !s2_free |-> in_stall)
		else $error("input not stalled behind a blocked final character");

endmodule
